// ===== design/indexed_ordered_list_engine_assert.svh =====
// assertion macros used by the list engine rtl
`ifndef INDEXED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IOLE_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IOLE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/iole_pkg.sv =====
// types and codes of the indexed ordered list engine
package iole_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_INSERT     = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_READ       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam int unsigned OUT_VALUE_BITS = 32;

  // per-cell load select
  typedef struct packed {
    logic take_new;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

// ===== design/iole_cell.sv =====
// one storage cell of the list chain
module iole_cell #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk,
  input  iole_pkg::cell_ctl_t          ctl,
  input  logic signed [VALUE_BITS-1:0] new_value,
  input  logic signed [VALUE_BITS-1:0] left_value,
  input  logic signed [VALUE_BITS-1:0] right_value,
  output logic signed [VALUE_BITS-1:0] value
);
  import iole_pkg::*;

  logic signed [VALUE_BITS-1:0] value_r;
  logic signed [VALUE_BITS-1:0] value_nxt;

  always_comb begin
    priority if (ctl.take_new) begin
      value_nxt = new_value;
    end else if (ctl.take_left) begin
      value_nxt = left_value;
    end else if (ctl.take_right) begin
      value_nxt = right_value;
    end else begin
      value_nxt = value_r;
    end
  end

  // payload only, contents undefined until written
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== design/indexed_ordered_list_engine.sv =====
// indexed ordered list engine: top level with the cell chain and its control
//
// keeps an ordered list of up to CAPACITY signed values, positions counted
// from 1 at the front. an item is taken at a clock edge where start is high
// and busy is low; busy never rises, so one item can be taken every cycle.
// each item gives exactly one result, shown on the out_ ports in the cycle
// after acceptance and marked by out_valid; the receiver cannot stall,
// so it must take every result in that cycle. the list lives in a row of
// CAPACITY cells: an insert or push makes every cell past the slot load
// from its left neighbor, a remove or pop makes every cell from the slot on
// load from its right neighbor, all at once. a read or pop takes the
// value through one CAPACITY-way select over the chain, which sets the
// longest path. entries hold no reset value; only entries below the count
// are ever read.
module indexed_ordered_list_engine #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W     = $clog2(CAPACITY)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input items
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_op,
  input  logic signed [31:0]       in_item_value,
  input  logic [CNT_W-1:0]         in_position,
  // results
  output logic                     out_valid,
  output logic signed [31:0]       out_read_value,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_entry_count
);
  import iole_pkg::*;

`include "indexed_ordered_list_engine_assert.svh"

  // handshake
  logic accept;

  // list state
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // result registers
  logic                      out_valid_r;
  logic signed [31:0]        read_r;
  logic signed [31:0]        read_nxt;
  status_t                   status_r;
  status_t                   status_nxt;

  // decoded operation
  logic                      do_ins;
  logic                      do_rem;
  logic [CNT_W-1:0]          slot;
  logic                      pos_ok;
  logic [CNT_W-1:0]          pos_m1;
  logic signed [VALUE_BITS-1:0] store_value;
  logic signed [VALUE_BITS-1:0] sel_value;

  // chain wiring
  logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
  cell_ctl_t                    cell_ctl   [CAPACITY];

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign pos_ok      = (in_position != '0) && (in_position <= count_r);
  assign pos_m1      = in_position - CNT_W'(1);
  assign store_value = VALUE_BITS'(in_item_value);

  // value at the addressed slot, low bits of the slot as index
  assign sel_value = cell_value[slot[IDX_W-1:0]];

  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    slot       = '0;
    count_nxt  = count_r;
    read_nxt   = '0;
    status_nxt = ST_OK;
    unique case (op_t'(in_op))
      OP_PUSH_BACK: begin
        slot = count_r;
        if (count_r == CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        slot = pos_m1;
        // full is tested before the position
        if (count_r == CNT_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        slot = count_r - CNT_W'(1);
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_rem    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          read_nxt  = 32'(sel_value);
        end
      end
      OP_POP_FRONT: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_rem    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          read_nxt  = 32'(sel_value);
        end
      end
      OP_REMOVE: begin
        slot = pos_m1;
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          do_rem    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        slot = pos_m1;
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          read_nxt = 32'(sel_value);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // the cell chain: each cell sees its neighbors and its own load select
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] left_v;
    logic signed [VALUE_BITS-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = store_value;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end

    assign cell_ctl[i].take_new   = accept && do_ins && (slot == CNT_W'(i));
    assign cell_ctl[i].take_left  = accept && do_ins && (CNT_W'(i) > slot);
    assign cell_ctl[i].take_right = accept && do_rem && (CNT_W'(i) >= slot);

    iole_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .new_value  (store_value),
      .left_value (left_v),
      .right_value(right_v),
      .value      (cell_value[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      read_r   <= read_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = read_r;
  assign out_status      = status_r;
  assign out_entry_count = count_r;

  // checks
  `IOLE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY),
    "entry count above capacity")
  `IOLE_ASSERT_NEXT(a_one_result, clk, rst_n, accept, out_valid_r,
    "accepted item gave no result")
  `IOLE_ASSERT_NEXT(a_no_extra, clk, rst_n, !accept, !out_valid_r,
    "result without an accepted item")
  `IOLE_ASSERT_NOW(a_full_count, clk, rst_n, out_valid_r && status_r == ST_FULL,
    count_r == CNT_W'(CAPACITY), "full status while list not full")
  `IOLE_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid_r && status_r == ST_EMPTY,
    count_r == '0 && read_r == '0, "empty status with entries or a value")

endmodule
